// ===== sv/rcs_pkg.sv =====
// Shared constants, control struct and CORDIC arctangent table for the converter.
package rcs_pkg;

  localparam int COORD_WIDTH_DEF    = 32;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int PHI_WIDTH_DEF      = 20;
  localparam int CORDIC_STEPS_DEF   = 20;
  localparam int DIST_WIDTH         = 32;
  localparam int ANG_WIDTH          = 32;
  localparam int CFG_IDX_WIDTH      = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROT_COL_X = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROT_COL_Y = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROT_COL_Z = 2'd2;

  localparam logic [ANG_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

  // Per-item flags that ride along the pipeline
  typedef struct packed {
    logic valid;
    logic zdist;  // distance was zero
    logic sat;    // |z| / dist reaches one
    logic neg;    // rotated z negative
    logic zxy;    // rotated x and y both zero
  } ctl_t;

  // arctan(2^-i) in units of 2^-32 turn
  function automatic logic [ANG_WIDTH-1:0] atan_turn(input int unsigned i);
    logic [ANG_WIDTH-1:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/rotated_cartesian_to_spherical.sv =====
// Top level: rotated Cartesian position to cos(theta) and azimuth, fully pipelined.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata: x_pos, y_pos, z_pos, dist_req
//  out_    | out | out_tvalid/out_tready| tdata: cos_theta, phi_angle; tuser: status
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data (one matrix column)
//
// One beat is accepted every cycle while the output is not stalled. The pipeline has
// two rotation stages, one set-up stage, one stage per CORDIC step / quotient bit,
// and the output register.
// The whole pipeline advances together whenever the output register is empty or
// being taken; a stall holds every stage, so nothing is dropped or repeated.
// Reset (rst_n low at a clock edge) clears all valid bits and loads the identity
// matrix. cfg_ready is always high.
module rotated_cartesian_to_spherical
  import rcs_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int PHI_WIDTH      = PHI_WIDTH_DEF,
  parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
  localparam int COEF_W  = COEF_FRAC_BITS + 2,
  localparam int IN_W    = 3 * COORD_WIDTH + DIST_WIDTH,
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W   = COEF_W + PHI_WIDTH,
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_TW-1:0]         in_tdata,   // x_pos, y_pos, z_pos, dist_req, pad
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_TW-1:0]        out_tdata,  // cos_theta, phi_angle, pad
  output logic                     out_tuser,  // status
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [3*COEF_W-1:0]      cfg_data
);

  localparam int ROT_FULL = COORD_WIDTH + COEF_W + 2;
  localparam int ROT_W    = (ROT_FULL > 64) ? 64 : ROT_FULL;
  localparam int CORD_W   = ((ROT_W > 60) ? 60 : ROT_W) + 2;
  localparam int REM_W    = ((ROT_W > DIST_WIDTH + COEF_FRAC_BITS) ?
                             ROT_W : DIST_WIDTH + COEF_FRAC_BITS) + 1;
  localparam int NSTG     = (CORDIC_STEPS > COEF_FRAC_BITS) ? CORDIC_STEPS : COEF_FRAC_BITS;
  localparam int DROP     = ANG_WIDTH - PHI_WIDTH;

  // Matrix columns; identity at reset
  logic [3*COEF_W-1:0] col_x_r, col_y_r, col_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_x_r <= (3*COEF_W)'(1) << COEF_FRAC_BITS;
      col_y_r <= (3*COEF_W)'(1) << (COEF_FRAC_BITS + COEF_W);
      col_z_r <= (3*COEF_W)'(1) << (COEF_FRAC_BITS + 2*COEF_W);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROT_COL_X: col_x_r <= cfg_data;
        REG_ROT_COL_Y: col_y_r <= cfg_data;
        REG_ROT_COL_Z: col_z_r <= cfg_data;
        default: ;  // unknown register: drop the write
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Global advance: move when the output slot is free or being emptied
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic                     rot_valid;
  logic signed [ROT_W-1:0]  rx, ry, rz;
  logic [DIST_WIDTH-1:0]    rot_dist;

  rcs_rotate #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_W     (COEF_W),
    .ROT_W      (ROT_W)
  ) u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .x_in     ($signed(in_tdata[0 +: COORD_WIDTH])),
    .y_in     ($signed(in_tdata[COORD_WIDTH +: COORD_WIDTH])),
    .z_in     ($signed(in_tdata[2*COORD_WIDTH +: COORD_WIDTH])),
    .dist_in  (in_tdata[3*COORD_WIDTH +: DIST_WIDTH]),
    .col_x    (col_x_r),
    .col_y    (col_y_r),
    .col_z    (col_z_r),
    .out_valid(rot_valid),
    .rx       (rx),
    .ry       (ry),
    .rz       (rz),
    .dist_out (rot_dist)
  );

  // Per-stage pipeline signals; index 0 is the set-up stage output
  ctl_t                      ctl_s  [NSTG+1];
  logic signed [CORD_W-1:0]  x_s    [NSTG+1];
  logic signed [CORD_W-1:0]  y_s    [NSTG+1];
  logic [ANG_WIDTH-1:0]      z_s    [NSTG+1];
  logic [REM_W-1:0]          rem_s  [NSTG+1];
  logic [DIST_WIDTH-1:0]     dist_s [NSTG+1];
  logic [COEF_FRAC_BITS-1:0] q_s    [NSTG+1];

  rcs_prep #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .ROT_W         (ROT_W),
    .CORD_W        (CORD_W),
    .REM_W         (REM_W)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(rot_valid),
    .rx      (rx),
    .ry      (ry),
    .rz      (rz),
    .dist_in (rot_dist),
    .ctl_out (ctl_s[0]),
    .x_out   (x_s[0]),
    .y_out   (y_s[0]),
    .z_out   (z_s[0]),
    .rem_out (rem_s[0]),
    .dist_out(dist_s[0])
  );

  assign q_s[0] = '0;

  for (genvar g = 0; g < NSTG; g++) begin : g_iter
    rcs_iter_stage #(
      .STEP          (g),
      .CORDIC_STEPS  (CORDIC_STEPS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .CORD_W        (CORD_W),
      .REM_W         (REM_W)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_in  (ctl_s[g]),
      .x_in    (x_s[g]),
      .y_in    (y_s[g]),
      .z_in    (z_s[g]),
      .rem_in  (rem_s[g]),
      .dist_in (dist_s[g]),
      .q_in    (q_s[g]),
      .ctl_out (ctl_s[g+1]),
      .x_out   (x_s[g+1]),
      .y_out   (y_s[g+1]),
      .z_out   (z_s[g+1]),
      .rem_out (rem_s[g+1]),
      .dist_out(dist_s[g+1]),
      .q_out   (q_s[g+1])
    );
  end

  // Output stage: offset the angle by a half turn, round to PHI_WIDTH, form cos(theta)
  ctl_t                  ctl_f;
  logic [ANG_WIDTH-1:0]  ang;
  logic [PHI_WIDTH-1:0]  phi_nxt, phi_r;
  logic [COEF_W-1:0]     cos_nxt, cos_r;
  logic                  status_r;

  assign ctl_f = ctl_s[NSTG];
  assign ang   = (ctl_f.zxy ? '0 : z_s[NSTG]) + HALF_TURN;

  if (DROP > 0) begin : g_round
    logic [ANG_WIDTH:0] ang_rnd;
    assign ang_rnd = {1'b0, ang} + ((ANG_WIDTH+1)'(1) << (DROP - 1));
    assign phi_nxt = ang_rnd[DROP +: PHI_WIDTH];
  end else begin : g_noround
    assign phi_nxt = PHI_WIDTH'(ang);
  end

  always_comb begin
    logic [COEF_W-1:0] mag;
    mag = ctl_f.sat ? (COEF_W'(1) << COEF_FRAC_BITS) : COEF_W'(q_s[NSTG]);
    if (ctl_f.zdist) begin
      cos_nxt = '0;
    end else if (ctl_f.neg) begin
      cos_nxt = COEF_W'(0) - mag;
    end else begin
      cos_nxt = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_f.valid;
    end
    if (en) begin
      cos_r    <= cos_nxt;
      phi_r    <= phi_nxt;
      status_r <= ctl_f.zdist;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({phi_r, cos_r});
  assign out_tuser  = status_r;

endmodule

// ===== sv/rcs_rotate.sv =====
// Matrix rotation: registered products, then registered dot-product sums.
module rcs_rotate
  import rcs_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COEF_W      = COEF_FRAC_BITS_DEF + 2,
  parameter int ROT_W       = 52
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] x_in,
  input  logic signed [COORD_WIDTH-1:0] y_in,
  input  logic signed [COORD_WIDTH-1:0] z_in,
  input  logic [DIST_WIDTH-1:0]         dist_in,
  input  logic [3*COEF_W-1:0]           col_x,
  input  logic [3*COEF_W-1:0]           col_y,
  input  logic [3*COEF_W-1:0]           col_z,
  output logic                          out_valid,
  output logic signed [ROT_W-1:0]       rx,
  output logic signed [ROT_W-1:0]       ry,
  output logic signed [ROT_W-1:0]       rz,
  output logic [DIST_WIDTH-1:0]         dist_out
);

  localparam int PW = COORD_WIDTH + COEF_W;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] prod_nxt [9];
  logic signed [PW-1:0] prod_r   [9];
  logic                 v1_r, v2_r;
  logic [DIST_WIDTH-1:0] dist1_r, dist2_r;
  logic signed [ROT_W-1:0] rx_r, ry_r, rz_r;

  always_comb begin
    logic signed [COEF_W-1:0]      k;
    logic signed [COORD_WIDTH-1:0] c;
    logic [3*COEF_W-1:0]           col;
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        col = (r == 0) ? col_x : ((r == 1) ? col_y : col_z);
        k   = $signed(col[j*COEF_W +: COEF_W]);
        c   = (j == 0) ? x_in : ((j == 1) ? y_in : z_in);
        prod_nxt[r*3+j] = PW'(k) * PW'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    if (en) begin
      prod_r  <= prod_nxt;
      dist1_r <= dist_in;
      dist2_r <= dist1_r;
      rx_r <= ROT_W'(SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]));
      ry_r <= ROT_W'(SW'(prod_r[3]) + SW'(prod_r[4]) + SW'(prod_r[5]));
      rz_r <= ROT_W'(SW'(prod_r[6]) + SW'(prod_r[7]) + SW'(prod_r[8]));
    end
  end

  assign out_valid = v2_r;
  assign rx        = rx_r;
  assign ry        = ry_r;
  assign rz        = rz_r;
  assign dist_out  = dist2_r;

endmodule

// ===== sv/rcs_prep.sv =====
// Set-up stage: z magnitude and saturation test, CORDIC prescale and half-plane fold.
module rcs_prep
  import rcs_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int ROT_W          = 52,
  parameter int CORD_W         = 54,
  parameter int REM_W          = 53
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [ROT_W-1:0]  rx,
  input  logic signed [ROT_W-1:0]  ry,
  input  logic signed [ROT_W-1:0]  rz,
  input  logic [DIST_WIDTH-1:0]    dist_in,
  output ctl_t                     ctl_out,
  output logic signed [CORD_W-1:0] x_out,
  output logic signed [CORD_W-1:0] y_out,
  output logic [ANG_WIDTH-1:0]     z_out,
  output logic [REM_W-1:0]         rem_out,
  output logic [DIST_WIDTH-1:0]    dist_out
);

  localparam int PS = (ROT_W > 60) ? ROT_W - 60 : 0;

  ctl_t                     ctl_nxt, ctl_r;
  logic signed [CORD_W-1:0] x_nxt, y_nxt, x_r, y_r;
  logic [ANG_WIDTH-1:0]     z_nxt, z_r;
  logic [REM_W-1:0]         rem_nxt, rem_r;
  logic [DIST_WIDTH-1:0]    dist_r;

  always_comb begin
    logic [ROT_W-1:0]        mag;
    logic signed [ROT_W-1:0] sx, sy, px, py;
    logic signed [CORD_W-1:0] cx, cy;
    mag = rz[ROT_W-1] ? (ROT_W'(0) - ROT_W'(rz)) : ROT_W'(rz);
    ctl_nxt.valid = in_valid;
    ctl_nxt.zdist = (dist_in == '0);
    ctl_nxt.neg   = rz[ROT_W-1];
    ctl_nxt.sat   = REM_W'(mag) >= (REM_W'(dist_in) << COEF_FRAC_BITS);
    ctl_nxt.zxy   = (rx == '0) && (ry == '0);
    rem_nxt       = REM_W'(mag);
    // shift both down together until each fits 59 bits plus sign
    px = rx;
    py = ry;
    for (int n = PS; n >= 0; n--) begin
      sx = rx >>> n;
      sy = ry >>> n;
      if (((sx >>> 59) == '0 || (sx >>> 59) == '1) &&
          ((sy >>> 59) == '0 || (sy >>> 59) == '1)) begin
        px = sx;
        py = sy;
      end
    end
    cx = CORD_W'(px);
    cy = CORD_W'(py);
    if (cx < 0) begin
      x_nxt = -cx;
      y_nxt = -cy;
      z_nxt = HALF_TURN;
    end else begin
      x_nxt = cx;
      y_nxt = cy;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      rem_r  <= rem_nxt;
      dist_r <= dist_in;
    end
  end

  assign ctl_out  = ctl_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;
  assign rem_out  = rem_r;
  assign dist_out = dist_r;

endmodule

// ===== sv/rcs_iter_stage.sv =====
// One pipeline step: CORDIC vectoring rotation and/or a restoring quotient bit.
module rcs_iter_stage
  import rcs_pkg::*;
#(
  parameter int STEP           = 0,
  parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int CORD_W         = 54,
  parameter int REM_W          = 53
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  ctl_t                        ctl_in,
  input  logic signed [CORD_W-1:0]    x_in,
  input  logic signed [CORD_W-1:0]    y_in,
  input  logic [ANG_WIDTH-1:0]        z_in,
  input  logic [REM_W-1:0]            rem_in,
  input  logic [DIST_WIDTH-1:0]       dist_in,
  input  logic [COEF_FRAC_BITS-1:0]   q_in,
  output ctl_t                        ctl_out,
  output logic signed [CORD_W-1:0]    x_out,
  output logic signed [CORD_W-1:0]    y_out,
  output logic [ANG_WIDTH-1:0]        z_out,
  output logic [REM_W-1:0]            rem_out,
  output logic [DIST_WIDTH-1:0]       dist_out,
  output logic [COEF_FRAC_BITS-1:0]   q_out
);

  localparam bit DO_ROT = (STEP < CORDIC_STEPS);
  localparam bit DO_DIV = (STEP < COEF_FRAC_BITS);
  localparam int QBIT   = DO_DIV ? COEF_FRAC_BITS - 1 - STEP : 0;

  ctl_t                      ctl_r;
  logic signed [CORD_W-1:0]  x_nxt, y_nxt, x_r, y_r;
  logic [ANG_WIDTH-1:0]      z_nxt, z_r;
  logic [REM_W-1:0]          rem_nxt, rem_r;
  logic [COEF_FRAC_BITS-1:0] q_nxt, q_r;
  logic [DIST_WIDTH-1:0]     dist_r;

  always_comb begin
    logic signed [CORD_W-1:0] dx, dy;
    logic [REM_W-1:0]         dsh;
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
    x_nxt = x_in;
    y_nxt = y_in;
    z_nxt = z_in;
    if (DO_ROT) begin
      if (y_in > 0) begin
        x_nxt = x_in + dx;
        y_nxt = y_in - dy;
        z_nxt = z_in + atan_turn(STEP);
      end else begin
        x_nxt = x_in - dx;
        y_nxt = y_in + dy;
        z_nxt = z_in - atan_turn(STEP);
      end
    end
    dsh     = REM_W'(dist_in) << QBIT;
    rem_nxt = rem_in;
    q_nxt   = q_in;
    if (DO_DIV && rem_in >= dsh) begin
      rem_nxt     = rem_in - dsh;
      q_nxt[QBIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      dist_r <= dist_in;
    end
  end

  assign ctl_out  = ctl_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;
  assign rem_out  = rem_r;
  assign q_out    = q_r;
  assign dist_out = dist_r;

endmodule

// ===== sv/rcs_checker.sv =====
// Port-level checker for the converter, bound to the top level.
module rcs_checker
  import rcs_pkg::*;
#(
  parameter int COEF_W = COEF_FRAC_BITS_DEF + 2,
  parameter int OUT_TW = 40
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata,
  input logic              out_tuser
);

  logic signed [COEF_W-1:0] cos_v;
  assign cos_v = $signed(out_tdata[COEF_W-1:0]);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> cos_v == '0)
    else $error("zero distance with nonzero cos_theta");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cos_v <= $signed(COEF_W'(1) << (COEF_W - 2)) &&
                   cos_v >= -$signed(COEF_W'(1) << (COEF_W - 2)))
    else $error("cos_theta beyond plus or minus one");

endmodule

bind rotated_cartesian_to_spherical rcs_checker #(
  .COEF_W(COEF_W),
  .OUT_TW(OUT_TW)
) u_rcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
